### hdl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared constants for the pending transaction table: default sizes,
// operation codes and result status codes.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int unsigned TableDepthDefault  = 16;
  localparam int unsigned PayloadBitsDefault = 64;
  localparam int unsigned TidW               = 32;
  localparam int unsigned StatusW            = 2;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusW-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL      = 2'd2;

endpackage

### hdl/pending_transaction_table.sv
// ----------------------------------------------------------------------------
// pending_transaction_table
// Tracks outstanding transactions in a fixed table. Add stores a payload in
// the lowest free slot under an id from a wrapping counter; lookup searches
// the valid slots for an id, returns the payload and optionally frees it.
// ----------------------------------------------------------------------------
// Add: one slot per cycle is checked for free, from slot 0 upward, and the
// result is handed through ST_DONE to the output register.
// Lookup: one RAM read per cycle through the single read port and one shared
// id comparator; the result is handed through ST_DONE to the output register.
// One item at a time: a new item is taken only in ST_IDLE, once the last result is in the output register.
// Reset clears the valid bits and the id counter at once; no clearing pass.
// ----------------------------------------------------------------------------
module pending_transaction_table #(
  parameter int unsigned TABLE_DEPTH  = ptt_pkg::TableDepthDefault,
  parameter int unsigned PAYLOAD_BITS = ptt_pkg::PayloadBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             opcode_i,
  input  logic [PAYLOAD_BITS-1:0]          payload_in_i,
  input  logic [ptt_pkg::TidW-1:0]         lookup_tid_i,
  input  logic                             remove_entry_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ptt_pkg::StatusW-1:0]      status_o,
  output logic [ptt_pkg::TidW-1:0]         assigned_tid_o,
  output logic [PAYLOAD_BITS-1:0]          payload_out_o
);

  localparam int unsigned IdxW  = $clog2(TABLE_DEPTH);
  localparam int unsigned RamW  = ptt_pkg::TidW + PAYLOAD_BITS;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ADD  = 4'b0010,
    ST_LOOK = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [TABLE_DEPTH-1:0]       valid_q, valid_d;
  logic [ptt_pkg::TidW-1:0]     id_counter_q, id_counter_d;
  logic [IdxW-1:0]              idx_q, idx_d;
  logic                         issue_done_q, issue_done_d;
  logic                         rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]              rd_idx_q, rd_idx_d;

  logic                         op_q, op_d;
  logic [PAYLOAD_BITS-1:0]      pay_q, pay_d;
  logic [ptt_pkg::TidW-1:0]     want_q, want_d;
  logic                         rm_q, rm_d;

  logic [ptt_pkg::StatusW-1:0]  res_status_q, res_status_d;
  logic [ptt_pkg::TidW-1:0]     res_tid_q, res_tid_d;
  logic [PAYLOAD_BITS-1:0]      res_pay_q, res_pay_d;

  logic                         out_valid_q, out_valid_d;
  logic [ptt_pkg::StatusW-1:0]  out_status_q, out_status_d;
  logic [ptt_pkg::TidW-1:0]     out_tid_q, out_tid_d;
  logic [PAYLOAD_BITS-1:0]      out_pay_q, out_pay_d;

  logic                         ram_we;
  logic                         ram_re;
  logic [RamW-1:0]              ram_rdata;
  logic [ptt_pkg::TidW-1:0]     rd_tid;
  logic [PAYLOAD_BITS-1:0]      rd_pay;
  logic                         hit;
  logic                         out_free;

  assign rd_tid   = ram_rdata[RamW-1 -: ptt_pkg::TidW];
  assign rd_pay   = ram_rdata[PAYLOAD_BITS-1:0];
  assign hit      = rd_vld_q && valid_q[rd_idx_q] && (rd_tid == want_q);
  assign out_free = !out_valid_q || out_ready_i;

  ptt_ram #(
    .Width (RamW),
    .Depth (TABLE_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i ({id_counter_q, pay_q}),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    id_counter_d = id_counter_q;
    idx_d        = idx_q;
    issue_done_d = issue_done_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    op_d         = op_q;
    pay_d        = pay_q;
    want_d       = want_q;
    rm_d         = rm_q;
    res_status_d = res_status_q;
    res_tid_d    = res_tid_q;
    res_pay_d    = res_pay_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_tid_d    = out_tid_q;
    out_pay_d    = out_pay_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d         = opcode_i;
          pay_d        = payload_in_i;
          want_d       = lookup_tid_i;
          rm_d         = remove_entry_i;
          idx_d        = '0;
          issue_done_d = 1'b0;
          state_d      = (opcode_i == ptt_pkg::OP_ADD) ? ST_ADD : ST_LOOK;
        end
      end
      ST_ADD: begin
        if (!valid_q[idx_q]) begin
          ram_we         = 1'b1;
          valid_d[idx_q] = 1'b1;
          res_status_d   = ptt_pkg::STATUS_OK;
          res_tid_d      = id_counter_q;
          res_pay_d      = '0;
          id_counter_d   = id_counter_q + ptt_pkg::TidW'(1);
          state_d        = ST_DONE;
        end else if (idx_q == LastIdx) begin
          res_status_d = ptt_pkg::STATUS_FULL;
          res_tid_d    = '0;
          res_pay_d    = '0;
          state_d      = ST_DONE;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_LOOK: begin
        if (hit) begin
          res_status_d = ptt_pkg::STATUS_OK;
          res_tid_d    = '0;
          res_pay_d    = rd_pay;
          if (rm_q) begin
            valid_d[rd_idx_q] = 1'b0;
          end
          state_d = ST_DONE;
        end else if (rd_vld_q && rd_idx_q == LastIdx) begin
          res_status_d = ptt_pkg::STATUS_NOT_FOUND;
          res_tid_d    = '0;
          res_pay_d    = '0;
          state_d      = ST_DONE;
        end else if (!issue_done_q) begin
          // read the next slot; its tag is compared in the following cycle
          ram_re       = 1'b1;
          rd_vld_d     = 1'b1;
          rd_idx_d     = idx_q;
          issue_done_d = (idx_q == LastIdx);
          if (idx_q != LastIdx) begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_tid_d    = res_tid_q;
          out_pay_d    = res_pay_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      id_counter_q <= '0;
      idx_q        <= '0;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      id_counter_q <= id_counter_d;
      idx_q        <= idx_d;
      issue_done_q <= issue_done_d;
      rd_vld_q     <= rd_vld_d;
      rd_idx_q     <= rd_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    pay_q        <= pay_d;
    want_q       <= want_d;
    rm_q         <= rm_d;
    res_status_q <= res_status_d;
    res_tid_q    <= res_tid_d;
    res_pay_q    <= res_pay_d;
    out_status_q <= out_status_d;
    out_tid_q    <= out_tid_d;
    out_pay_q    <= out_pay_d;
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign assigned_tid_o = out_tid_q;
  assign payload_out_o  = out_pay_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  a_counter_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (id_counter_q != $past(id_counter_q)) |->
      (id_counter_q == $past(id_counter_q) + ptt_pkg::TidW'(1)))
    else $error("id counter moved by other than one");

  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && res_status_q == ptt_pkg::STATUS_FULL) |-> (&valid_q))
    else $error("table full reported with a free slot");

  a_miss_on_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && res_status_q == ptt_pkg::STATUS_NOT_FOUND) |->
      (op_q == ptt_pkg::OP_LOOKUP))
    else $error("not-found reported for an add");

endmodule

### hdl/ptt_ram.sv
// ----------------------------------------------------------------------------
// ptt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ptt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
